FILE: hdl/pdnr_pkg.sv
// ----------------------------------------------------------------------------
// PLL divider search package
// Shared types and constants of the nearest-ratio divider search.
// ----------------------------------------------------------------------------
package pdnr_pkg;

    localparam int TW = 9;   // target frequency and limit width
    localparam int CW = 8;   // control byte width
    localparam int NW = 7;   // N divider width
    localparam int MW = 6;   // M divider width

    localparam logic [NW-1:0] N_FIRST = 7'd21;
    localparam logic [NW-1:0] N_LAST  = 7'd125;
    localparam logic [MW-1:0] M_FIRST = 6'd20;
    localparam logic [MW-1:0] M_END   = 6'd59;
    // From this N on, the lower M bound N/2+1 rises above M_FIRST.
    localparam logic [NW-1:0] N_MSTART_GROW = 7'd40;

    localparam logic [3:0] SEL_HI_1 = 4'd1;
    localparam logic [3:0] SEL_HI_5 = 4'd5;
    localparam logic [3:0] SEL_LO_4 = 4'd4;
    localparam logic [3:0] SEL_LO_8 = 4'd8;
    localparam logic [3:0] SEL_LO_9 = 4'd9;

    localparam logic [CW-1:0] CTRL_WE_MASK   = 8'h01;
    localparam logic [CW-1:0] CTRL_KEEP_MASK = 8'h7F;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_NONE = 1'b1;

    localparam logic REG_LOW_LIMIT  = 1'b0;
    localparam logic REG_HIGH_LIMIT = 1'b1;

    typedef struct packed {
        logic          valid;
        logic [NW-1:0] n;
        logic [MW-1:0] m;
    } pdnr_cand_t;

    typedef struct packed {
        logic          found;
        logic [NW-1:0] n;
        logic [MW-1:0] m;
    } pdnr_best_t;

endpackage

FILE: hdl/pll_divider_nearest_ratio_search_unit.sv
// ----------------------------------------------------------------------------
// PLL divider nearest-ratio search unit
// Picks the PLL divider pair M/N closest to reference/target for a requested
// bus frequency, after checking the target against two limit registers.
// ----------------------------------------------------------------------------
//  Channel  Handshake          Payload
//  input    in_valid/in_stall  target_freq, control_byte
//  output   out_valid/out_stall status, n_divider, m_divider,
//                              m_register_byte, control_byte_out
//  config   cfg_we             cfg_index, cfg_data
//
//  A word in limits is walked through every candidate pair and every N step
//  in ST_SEARCH, through a single accumulator datapath and one compare unit,
//  then through ST_DRAIN and ST_FINISH before the result is loaded.
//  A word outside the limits skips the search and goes straight to ST_FINISH.
//  in_stall is high from acceptance until the result is loaded; a stalled
//  output holds its word while the next input word may already be accepted.
//  Reset sets limits to 100 and 300 MHz; clears state, candidate, out_valid.
// ----------------------------------------------------------------------------
module pll_divider_nearest_ratio_search_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [pdnr_pkg::TW-1:0]   target_freq,
    input  logic [pdnr_pkg::CW-1:0]   control_byte,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic                      status,
    output logic [pdnr_pkg::NW-1:0]   n_divider,
    output logic [pdnr_pkg::MW-1:0]   m_divider,
    output logic [pdnr_pkg::CW-1:0]   m_register_byte,
    output logic [pdnr_pkg::CW-1:0]   control_byte_out,
    input  logic                      cfg_we,
    input  logic [0:0]                cfg_index,
    input  logic [pdnr_pkg::TW-1:0]   cfg_data
);
    import pdnr_pkg::*;

    localparam int TSW = TW + FRAC_BITS;      // target scaled
    localparam int PRW = 8 + FRAC_BITS;       // reference in Q8.FRAC_BITS
    localparam int AW  = 15 + FRAC_BITS;      // M*ts, P*N and their difference
    localparam int NTW = 16 + FRAC_BITS;      // N*ts

    localparam longint unsigned REF_HI  =
        ((64'd127994667 << FRAC_BITS) + 64'd500000) / 64'd1000000;
    localparam longint unsigned REF_LO  = ((64'd95966 << FRAC_BITS) + 64'd500) / 64'd1000;
    localparam longint unsigned REF_DEF = ((64'd191992 << FRAC_BITS) + 64'd500) / 64'd1000;
    localparam longint unsigned REF_HI_N0  = REF_HI * 64'd21;
    localparam longint unsigned REF_LO_N0  = REF_LO * 64'd21;
    localparam longint unsigned REF_DEF_N0 = REF_DEF * 64'd21;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SEARCH = 2'd1;
    localparam logic [1:0] ST_DRAIN  = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0]     state_reg, state_next;
    logic [TW-1:0]  low_reg, low_next;
    logic [TW-1:0]  high_reg, high_next;
    logic [CW-1:0]  ctrl_reg, ctrl_next;
    logic [NW-1:0]  n_reg, n_next;
    logic [MW-1:0]  m_reg, m_next;
    logic [MW-1:0]  mstart_reg, mstart_next;
    logic [TSW-1:0] ts_reg, ts_next;
    logic [PRW-1:0] p_reg, p_next;
    logic [AW-1:0]  a_reg, a_next;
    logic [AW-1:0]  ms_reg, ms_next;
    logic [AW-1:0]  b_reg, b_next;
    logic [NTW-1:0] nts_reg, nts_next;
    pdnr_cand_t     cand_reg, cand_next;
    logic [AW-1:0]  err_reg, err_next;
    logic [NTW-1:0] cnts_reg, cnts_next;

    logic           out_valid_reg, out_valid_next;
    logic           status_reg, status_next;
    logic [NW-1:0]  n_out_reg, n_out_next;
    logic [MW-1:0]  m_out_reg, m_out_next;
    logic [CW-1:0]  ctrl_out_reg, ctrl_out_next;

    logic           accept;
    logic           out_free;
    logic           in_limits;
    logic [3:0]     sel;
    logic [PRW-1:0] p_sel;
    logic [AW-1:0]  pn0_sel;
    logic           m_ok;
    logic [NW-1:0]  n_step;
    logic           mstart_inc;
    pdnr_best_t     best;

    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != ST_IDLE);
    assign in_limits = (target_freq >= low_reg) && (target_freq <= high_reg);
    assign sel = control_byte[4:1];

    always_comb
    begin
        unique case (sel) inside
            SEL_HI_1, SEL_HI_5:
            begin
                p_sel   = PRW'(REF_HI);
                pn0_sel = AW'(REF_HI_N0);
            end
            SEL_LO_4, SEL_LO_8, SEL_LO_9:
            begin
                p_sel   = PRW'(REF_LO);
                pn0_sel = AW'(REF_LO_N0);
            end
            default:
            begin
                p_sel   = PRW'(REF_DEF);
                pn0_sel = AW'(REF_DEF_N0);
            end
        endcase
    end

    // Configuration writes.
    always_comb
    begin
        low_next  = low_reg;
        high_next = high_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_LOW_LIMIT:  low_next  = cfg_data;
                REG_HIGH_LIMIT: high_next = cfg_data;
                default:        ;
            endcase
        end
    end

    // Search sequencer. Products M*ts, P*N and N*ts are kept as running sums.
    assign m_ok       = (NW'(m_reg) < n_reg) && (m_reg < M_END);
    assign n_step     = n_reg + NW'(1);
    assign mstart_inc = !n_step[0] && (n_step >= N_MSTART_GROW);

    always_comb
    begin
        state_next  = state_reg;
        ctrl_next   = ctrl_reg;
        n_next      = n_reg;
        m_next      = m_reg;
        mstart_next = mstart_reg;
        ts_next     = ts_reg;
        p_next      = p_reg;
        a_next      = a_reg;
        ms_next     = ms_reg;
        b_next      = b_reg;
        nts_next    = nts_reg;
        cand_next   = '0;
        err_next    = err_reg;
        cnts_next   = cnts_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    ctrl_next   = (control_byte | CTRL_WE_MASK) & CTRL_KEEP_MASK;
                    n_next      = N_FIRST;
                    m_next      = M_FIRST;
                    mstart_next = M_FIRST;
                    ts_next     = {target_freq, {FRAC_BITS{1'b0}}};
                    p_next      = p_sel;
                    a_next      = AW'({target_freq, {FRAC_BITS{1'b0}}}) * AW'(M_FIRST);
                    ms_next     = AW'({target_freq, {FRAC_BITS{1'b0}}}) * AW'(M_FIRST);
                    b_next      = pn0_sel;
                    nts_next    = NTW'({target_freq, {FRAC_BITS{1'b0}}}) * NTW'(N_FIRST);
                    state_next  = in_limits ? ST_SEARCH : ST_FINISH;
                end
            end
            ST_SEARCH:
            begin
                if (m_ok)
                begin
                    cand_next.valid = 1'b1;
                    cand_next.n     = n_reg;
                    cand_next.m     = m_reg;
                    err_next        = (a_reg > b_reg) ? a_reg - b_reg : b_reg - a_reg;
                    cnts_next       = nts_reg;
                    m_next          = m_reg + MW'(1);
                    a_next          = a_reg + AW'(ts_reg);
                end
                else if (n_reg == N_LAST)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    n_next      = n_step;
                    mstart_next = mstart_reg + MW'(mstart_inc);
                    ms_next     = mstart_inc ? ms_reg + AW'(ts_reg) : ms_reg;
                    a_next      = ms_next;
                    m_next      = mstart_next;
                    b_next      = b_reg + AW'(p_reg);
                    nts_next    = nts_reg + NTW'(ts_reg);
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output word register.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        n_out_next     = n_out_reg;
        m_out_next     = m_out_reg;
        ctrl_out_next  = ctrl_out_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (state_reg == ST_FINISH && out_free)
        begin
            out_valid_next = 1'b1;
            if (best.found)
            begin
                status_next   = STATUS_OK;
                n_out_next    = best.n;
                m_out_next    = best.m;
                ctrl_out_next = ctrl_reg;
            end
            else
            begin
                status_next   = STATUS_NONE;
                n_out_next    = '0;
                m_out_next    = '0;
                ctrl_out_next = '0;
            end
        end
    end

    pdnr_best_track #(
        .AW  (AW),
        .NTW (NTW)
    ) u_best (
        .clk   (clk),
        .rst_n (rst_n),
        .start (accept),
        .cand  (cand_reg),
        .err   (err_reg),
        .nts   (cnts_reg),
        .best  (best)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            low_reg       <= TW'(100);
            high_reg      <= TW'(300);
            cand_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            low_reg       <= low_next;
            high_reg      <= high_next;
            cand_reg      <= cand_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ctrl_reg     <= ctrl_next;
        n_reg        <= n_next;
        m_reg        <= m_next;
        mstart_reg   <= mstart_next;
        ts_reg       <= ts_next;
        p_reg        <= p_next;
        a_reg        <= a_next;
        ms_reg       <= ms_next;
        b_reg        <= b_next;
        nts_reg      <= nts_next;
        err_reg      <= err_next;
        cnts_reg     <= cnts_next;
        status_reg   <= status_next;
        n_out_reg    <= n_out_next;
        m_out_reg    <= m_out_next;
        ctrl_out_reg <= ctrl_out_next;
    end

    assign out_valid        = out_valid_reg;
    assign status           = status_reg;
    assign n_divider        = n_out_reg;
    assign m_divider        = m_out_reg;
    assign m_register_byte  = (m_out_reg == '0) ? '0 : {1'b0, m_out_reg, 1'b1};
    assign control_byte_out = ctrl_out_reg;

`ifndef ASSERT_OFF
    a_result_pair: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == STATUS_OK |->
            n_divider >= N_FIRST && m_divider >= M_FIRST && NW'(m_divider) < n_divider)
        else $error("delivered divider pair outside the search range");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input not held off after a word was accepted");

    a_cand_in_search: assert property (@(posedge clk) disable iff (!rst_n)
        cand_reg.valid |-> state_reg == ST_SEARCH || state_reg == ST_DRAIN)
        else $error("candidate pending outside the search");
`endif

endmodule

FILE: hdl/pdnr_best_track.sv
// ----------------------------------------------------------------------------
// PLL divider search best-candidate tracker
// Compares each candidate error against N*ts before a hit, then against the
// best so far by cross multiplication; keeps the first strictly better pair.
// ----------------------------------------------------------------------------
module pdnr_best_track #(
    parameter int AW  = 31,
    parameter int NTW = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  pdnr_pkg::pdnr_cand_t cand,
    input  logic [AW-1:0]        err,
    input  logic [NTW-1:0]       nts,
    output pdnr_pkg::pdnr_best_t best
);
    import pdnr_pkg::*;

    localparam int PW = AW + NW;

    logic          found_reg;
    logic          found_next;
    logic [NW-1:0] best_n_reg;
    logic [NW-1:0] best_n_next;
    logic [MW-1:0] best_m_reg;
    logic [MW-1:0] best_m_next;
    logic [AW-1:0] best_err_reg;
    logic [AW-1:0] best_err_next;
    logic [PW-1:0] lhs;
    logic [PW-1:0] rhs;
    logic          better;

    // Before any hit, a candidate's error must be below N*ts, so its ratio misses by less than one.
    always_comb
    begin
        if (found_reg)
        begin
            lhs = PW'(err) * PW'(best_n_reg);
            rhs = PW'(best_err_reg) * PW'(cand.n);
        end
        else
        begin
            lhs = PW'(err);
            rhs = PW'(nts);
        end
        better = cand.valid && (lhs < rhs);
    end

    always_comb
    begin
        found_next    = found_reg;
        best_n_next   = best_n_reg;
        best_m_next   = best_m_reg;
        best_err_next = best_err_reg;
        if (start)
        begin
            found_next = 1'b0;
        end
        else if (better)
        begin
            found_next    = 1'b1;
            best_n_next   = cand.n;
            best_m_next   = cand.m;
            best_err_next = err;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else
        begin
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_n_reg   <= best_n_next;
        best_m_reg   <= best_m_next;
        best_err_reg <= best_err_next;
    end

    assign best.found = found_reg;
    assign best.n     = best_n_reg;
    assign best.m     = best_m_reg;

`ifndef ASSERT_OFF
    a_best_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        found_reg |-> best_n_reg >= N_FIRST && best_m_reg >= M_FIRST &&
                      best_m_reg < M_END && best_m_reg < best_n_reg)
        else $error("best pair outside the search range");

    a_found_from_cand: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(found_reg) |-> $past(cand.valid))
        else $error("best pair appeared without a candidate");

    a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> !found_reg)
        else $error("start did not clear the best pair");
`endif

endmodule
